// ===== sv/dq_pkg.sv =====
// ----------------------------------------------------------------------------
// Deque package
// Shared operation codes, status codes, controller states and field widths.
// ----------------------------------------------------------------------------
package dq_pkg;

    localparam int OPCODE_W    = 2;
    localparam int VALUE_W     = 32;
    localparam int STATUS_W    = 2;
    localparam int OCC_W       = 5;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 40;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_REAR  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_REAR   = 2'd3
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_OUT  = 2'd2
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
    } t_dq_cmd;

endpackage

// ===== sv/dq_ctrl.sv =====
// ----------------------------------------------------------------------------
// Deque controller
// Sequences one item at a time: take it, execute it, present the result.
// ----------------------------------------------------------------------------
module dq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    output logic            o_m_tvalid,
    input  logic            i_m_tready,
    output dq_pkg::t_dq_cmd o_cmd
);
    import dq_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_m_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_s_tready = 1'b0;
        o_m_tvalid = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.load = i_s_tvalid;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            S_OUT: begin
                o_m_tvalid = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ===== sv/dq_datapath.sv =====
// ----------------------------------------------------------------------------
// Deque datapath
// Circular slot memory with a front index and an occupancy count.
// ----------------------------------------------------------------------------
module dq_datapath #(
    parameter int DEPTH     = 16,
    parameter int WORD_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  dq_pkg::t_dq_cmd              i_cmd,
    input  logic [dq_pkg::OPCODE_W-1:0]  i_opcode,
    input  logic [dq_pkg::VALUE_W-1:0]   i_push_value,
    output logic [dq_pkg::VALUE_W-1:0]   o_pop_value,
    output dq_pkg::t_status              o_status,
    output logic [dq_pkg::OCC_W-1:0]     o_occupancy
);
    import dq_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SB    = (WORD_BITS < VALUE_W) ? WORD_BITS : VALUE_W;

    logic [SB-1:0]    r_mem [DEPTH];
    t_opcode          r_op;
    logic [SB-1:0]    r_val;
    logic [IDX_W-1:0] r_front;
    logic [CNT_W-1:0] r_count;
    t_status          r_status;
    logic             r_pop_ok;
    logic [SB-1:0]    r_rd;

    logic             full;
    logic             empty;
    logic             is_push;
    logic [IDX_W-1:0] front_dec;
    logic [IDX_W-1:0] front_inc;
    logic [IDX_W:0]   rear_sum;
    logic [IDX_W-1:0] rear_pos;
    logic [IDX_W-1:0] addr;
    logic             do_write;
    logic             do_read;

    assign full    = (r_count == CNT_W'(DEPTH));
    assign empty   = (r_count == '0);
    assign is_push = (r_op == OP_PUSH_FRONT) || (r_op == OP_PUSH_REAR);

    assign front_dec = (r_front == '0) ? IDX_W'(DEPTH - 1) : r_front - 1'b1;
    assign front_inc = (r_front == IDX_W'(DEPTH - 1)) ? '0 : r_front + 1'b1;

    always_comb begin
        rear_sum = {1'b0, r_front} + (is_push ? (IDX_W+1)'(r_count)
                                              : (IDX_W+1)'(r_count - 1'b1));
        if (rear_sum >= (IDX_W+1)'(DEPTH)) begin
            rear_sum = rear_sum - (IDX_W+1)'(DEPTH);
        end
        rear_pos = rear_sum[IDX_W-1:0];
    end

    always_comb begin
        case (r_op)
            OP_PUSH_FRONT: addr = front_dec;
            OP_POP_FRONT:  addr = r_front;
            default:       addr = rear_pos;
        endcase
    end

    assign do_write = i_cmd.exec && is_push && !full;
    assign do_read  = i_cmd.exec && !is_push && !empty;

    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_mem[addr] <= r_val;
        end
        if (do_read) begin
            r_rd <= r_mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= t_opcode'(i_opcode);
            r_val <= i_push_value[SB-1:0];
        end
        if (i_cmd.exec) begin
            r_pop_ok <= do_read;
            if (is_push) begin
                r_status <= full ? ST_OVERFLOW : ST_DONE;
            end else begin
                r_status <= empty ? ST_UNDERFLOW : ST_DONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
        end else begin
            if (do_write) begin
                r_count <= r_count + 1'b1;
                if (r_op == OP_PUSH_FRONT) begin
                    r_front <= front_dec;
                end
            end else if (do_read) begin
                r_count <= r_count - 1'b1;
                if (r_op == OP_POP_FRONT) begin
                    r_front <= front_inc;
                end
            end
        end
    end

    assign o_pop_value = r_pop_ok ? VALUE_W'(r_rd) : '0;
    assign o_status    = r_status;
    assign o_occupancy = OCC_W'(r_count);

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("occupancy count exceeds depth");

    a_front_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_front <= IDX_W'(DEPTH - 1))
        else $error("front index out of range");

    a_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec && is_push && full |=>
            $stable(r_count) && $stable(r_front) && r_status == ST_OVERFLOW)
        else $error("push on full queue changed state");

    a_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec && !is_push && empty |=>
            r_count == '0 && !r_pop_ok && r_status == ST_UNDERFLOW)
        else $error("pop on empty queue misreported");
`endif

endmodule

// ===== sv/double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue
// Circular-buffer deque of unsigned words with push and pop at either end.
// ----------------------------------------------------------------------------
// Each item is one operation and gives exactly one result item. The block
// handles one item at a time. An item is taken in the IDLE state and the slot
// memory is accessed in the EXEC state that follows. The result item is
// presented in the OUT state, which follows EXEC. The next item can be taken
// only after the result item has been accepted on i_m_tready and the
// controller is back in IDLE. This order is set by the registered read of the
// single-port slot memory and by the controller handling one item at a time.
// The slot memory needs no clearing pass after reset, so the block is ready
// as soon as reset is released.
module double_ended_queue #(
    parameter int DEPTH     = 16,
    parameter int WORD_BITS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // push_value[31:0]
    input  logic [dq_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    // opcode[1:0]
    input  logic [dq_pkg::OPCODE_W-1:0]     i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // pop_value[31:0], occupancy[36:32], zero fill[39:37]
    output logic [dq_pkg::OUT_TDATA_W-1:0]  o_m_tdata,
    // status[1:0]
    output logic [dq_pkg::STATUS_W-1:0]     o_m_tuser
);
    import dq_pkg::*;

    t_dq_cmd              cmd;
    logic [VALUE_W-1:0]   pop_value;
    t_status              status;
    logic [OCC_W-1:0]     occupancy;

    dq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (cmd)
    );

    dq_datapath #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_opcode     (i_s_tuser),
        .i_push_value (i_s_tdata[VALUE_W-1:0]),
        .o_pop_value  (pop_value),
        .o_status     (status),
        .o_occupancy  (occupancy)
    );

    assign o_m_tdata = {{(OUT_TDATA_W - VALUE_W - OCC_W){1'b0}}, occupancy, pop_value};
    assign o_m_tuser = status;

endmodule
